// ----- rtl/wcim_pkg.sv -----
`default_nettype none
package wcim_pkg;

  localparam int WINDOW_COUNT     = 8;
  localparam int MINUTES_PER_HOUR = 60;
  localparam int HOURS_PER_DAY    = 24;
  localparam int DAYS_PER_WEEK    = 7;
  localparam int MINUTES_PER_DAY  = MINUTES_PER_HOUR * HOURS_PER_DAY;

  // Index into the window table, and a count that can also hold the table size.
  localparam int SLOT_IDX_W = (WINDOW_COUNT > 1) ? $clog2(WINDOW_COUNT) : 1;
  localparam int SLOT_CNT_W = $clog2(WINDOW_COUNT + 1);

  // Widest dividend seen by the normalizer: a 16-bit field plus a small carry.
  localparam int RAW_W  = 17;
  localparam int WMIN_W = 14;
  localparam int WIN_W  = 2 * WMIN_W;

  typedef enum logic [2:0] {
    OP_ADD_MIN    = 3'd0,
    OP_ADD_HOUR   = 3'd1,
    OP_ADD_DAY    = 3'd2,
    OP_SET_TIME   = 3'd3,
    OP_SET_WINDOW = 3'd4
  } op_t;

  typedef struct packed {
    logic [2:0]  operation;
    logic [15:0] amount;
    logic [15:0] time_day;
    logic [15:0] time_hour;
    logic [15:0] time_min;
    logic [15:0] end_day;
    logic [15:0] end_hour;
    logic [15:0] end_min;
    logic [7:0]  slot;
  } wcim_in_t;

  typedef struct packed {
    logic [2:0] cur_day;
    logic [4:0] cur_hour;
    logic [5:0] cur_min;
    logic [3:0] active_slot;
  } wcim_out_t;

  typedef struct packed {
    logic [2:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
  } clk_time_t;

  typedef struct packed {
    logic [RAW_W-1:0] day;
    logic [RAW_W-1:0] hour;
    logic [RAW_W-1:0] minute;
  } raw_time_t;

  typedef struct packed {
    logic                  done;
    logic [SLOT_CNT_W-1:0] slot;
  } scan_status_t;

  // Minute of the week for a normalized time.
  function automatic logic [WMIN_W-1:0] week_minute(input clk_time_t t);
    logic [WMIN_W-1:0] day_part;
    logic [WMIN_W-1:0] hour_part;
    day_part  = WMIN_W'(int'(t.day) * MINUTES_PER_DAY);
    hour_part = WMIN_W'(int'(t.hour) * MINUTES_PER_HOUR);
    return day_part + hour_part + WMIN_W'(t.minute);
  endfunction

endpackage
`default_nettype wire

// ----- rtl/weekly_clock_interval_matcher.sv -----
// Channel  | Ports                      | Handshake
// ---------+----------------------------+-------------------------------------------
// input    | start, busy, in_item       | transaction taken when start && !busy
// result   | out_valid, out_result      | one-cycle strobe, receiver cannot stall
//
// Each transaction yields one result. A clock operation normalizes the new time once,
// a window write normalizes its start and then its end, and an unused code goes
// straight to the search. A normalization resolves three carries (minute, hour, day),
// each in a multiply state and a fix state, and the search reads one entry per cycle.
// Reset is synchronous and active low; it zeroes the clock and clears the window valid
// bits. The receiver cannot stall; a new transaction can be taken in the strobe cycle.
`default_nettype none
module weekly_clock_interval_matcher import wcim_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  input  wire wcim_in_t in_item,
  output logic          busy,
  output logic          out_valid,
  output wcim_out_t     out_result
);

  // Top-level sequencer. NORM_A normalizes the clock update or the window start,
  // NORM_B the window end, SCAN launches the window search and WAIT collects it.
  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_NORM_A = 5'b00010,
    ST_NORM_B = 5'b00100,
    ST_SCAN   = 5'b01000,
    ST_WAIT   = 5'b10000
  } state_t;

  state_t                state_r, state_nxt;
  op_t                   op_r;
  raw_time_t             raw_end_r;
  logic [SLOT_IDX_W-1:0] slot_r;
  logic [WMIN_W-1:0]     start_wm_r;
  clk_time_t             clock_r;
  logic [WINDOW_COUNT-1:0] valid_r;
  logic                  out_valid_r;
  wcim_out_t             out_r;

  op_t                   in_op;
  logic                  in_known;
  logic                  accept;
  raw_time_t             raw_a;
  logic [SLOT_IDX_W-1:0] slot_sat;

  logic                  norm_start;
  raw_time_t             norm_raw;
  logic                  norm_done;
  clk_time_t             norm_res;
  logic [WMIN_W-1:0]     norm_wm;

  logic                  ram_we;
  logic [WIN_W-1:0]      ram_wdata;
  logic [SLOT_IDX_W-1:0] ram_raddr;
  logic [WIN_W-1:0]      ram_rdata;

  logic                  scan_start;
  scan_status_t          scan_status;
  logic [WMIN_W-1:0]     now_wm;

  assign busy     = (state_r != ST_IDLE);
  assign accept   = start && !busy;
  assign in_op    = op_t'(in_item.operation);
  assign in_known = in_op inside {OP_ADD_MIN, OP_ADD_HOUR, OP_ADD_DAY, OP_SET_TIME,
                                  OP_SET_WINDOW};

  // Slot numbers beyond the table land on its last entry.
  assign slot_sat = (in_item.slot > 8'(WINDOW_COUNT - 1)) ?
                    SLOT_IDX_W'(WINDOW_COUNT - 1) : in_item.slot[SLOT_IDX_W-1:0];

  // Raw time handed to the normalizer when a transaction is taken. The sums are
  // formed at full width so that any 16-bit amount carries correctly.
  always_comb begin
    raw_a.day    = RAW_W'(clock_r.day);
    raw_a.hour   = RAW_W'(clock_r.hour);
    raw_a.minute = RAW_W'(clock_r.minute);
    case (in_op)
      OP_ADD_MIN:  raw_a.minute = RAW_W'(clock_r.minute) + RAW_W'(in_item.amount);
      OP_ADD_HOUR: raw_a.hour   = RAW_W'(clock_r.hour) + RAW_W'(in_item.amount);
      OP_ADD_DAY:  raw_a.day    = RAW_W'(clock_r.day) + RAW_W'(in_item.amount);
      OP_SET_TIME, OP_SET_WINDOW: begin
        raw_a.day    = RAW_W'(in_item.time_day);
        raw_a.hour   = RAW_W'(in_item.time_hour);
        raw_a.minute = RAW_W'(in_item.time_min);
      end
      default: ;
    endcase
  end

  // The second normalization of a window write reuses the same unit for the end.
  assign norm_start = (accept && in_known) ||
                      (state_r == ST_NORM_A && norm_done && op_r == OP_SET_WINDOW);
  assign norm_raw   = (state_r == ST_IDLE) ? raw_a : raw_end_r;
  assign norm_wm    = week_minute(norm_res);

  wcim_norm u_norm (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (norm_start),
    .raw    (norm_raw),
    .done   (norm_done),
    .result (norm_res)
  );

  // A window is stored as its lower and upper minute of the week, swapped when
  // given out of order. The write always lands before the search starts reading.
  assign ram_we    = (state_r == ST_NORM_B) && norm_done;
  assign ram_wdata = (start_wm_r < norm_wm) ? {start_wm_r, norm_wm} : {norm_wm, start_wm_r};

  wcim_ram #(
    .WIDTH (WIN_W),
    .DEPTH (WINDOW_COUNT)
  ) u_win_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (slot_r),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign scan_start = (state_r == ST_SCAN);
  assign now_wm     = week_minute(clock_r);

  wcim_scan u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (scan_start),
    .now     (now_wm),
    .valid   (valid_r),
    .rd_data (ram_rdata),
    .rd_addr (ram_raddr),
    .status  (scan_status)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = in_known ? ST_NORM_A : ST_SCAN;
      end
      ST_NORM_A: begin
        if (norm_done) state_nxt = (op_r == OP_SET_WINDOW) ? ST_NORM_B : ST_SCAN;
      end
      ST_NORM_B: begin
        if (norm_done) state_nxt = ST_SCAN;
      end
      ST_SCAN: state_nxt = ST_WAIT;
      ST_WAIT: begin
        if (scan_status.done) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control state: sequencer, clock, window valid bits and the result strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      clock_r     <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == ST_WAIT) && scan_status.done;
      if (state_r == ST_NORM_A && norm_done && op_r != OP_SET_WINDOW) begin
        clock_r <= norm_res;
      end
      if (ram_we) begin
        valid_r[slot_r] <= 1'b1;
      end
    end
  end

  // Transaction payload and the result register.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r             <= in_op;
      slot_r           <= slot_sat;
      raw_end_r.day    <= RAW_W'(in_item.end_day);
      raw_end_r.hour   <= RAW_W'(in_item.end_hour);
      raw_end_r.minute <= RAW_W'(in_item.end_min);
    end
    if (state_r == ST_NORM_A && norm_done) begin
      start_wm_r <= norm_wm;
    end
    if (state_r == ST_WAIT && scan_status.done) begin
      out_r.cur_day     <= clock_r.day;
      out_r.cur_hour    <= clock_r.hour;
      out_r.cur_min     <= clock_r.minute;
      out_r.active_slot <= 4'(scan_status.slot);
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_r;

  // A result is only ever presented once the sequencer has returned to idle.
  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (state_r == ST_IDLE))
    else $error("result strobe while the sequencer is busy");

  // Every taken transaction keeps the block busy in the following cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("transaction taken but block not busy afterwards");

  // The reported time is always normalized and the slot never exceeds the table size.
  a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (int'(out_result.cur_min) < MINUTES_PER_HOUR) &&
                  (int'(out_result.cur_hour) < HOURS_PER_DAY) &&
                  (int'(out_result.cur_day) < DAYS_PER_WEEK) &&
                  (int'(out_result.active_slot) <= WINDOW_COUNT))
    else $error("result out of range");

  // The table is written only while the window end is being normalized.
  a_write_in_norm_b: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (op_r == OP_SET_WINDOW) && norm_done)
    else $error("window table written outside a window transaction");

endmodule
`default_nettype wire

// ----- rtl/wcim_ram.sv -----
`default_nettype none
module wcim_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                                     clk,
  input  wire logic                                     wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                         wr_data,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data <= mem_r[rd_addr];
  end

endmodule
`default_nettype wire

// ----- rtl/wcim_norm.sv -----
`default_nettype none
module wcim_norm import wcim_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  input  wire raw_time_t raw,
  output logic           done,
  output clk_time_t      result
);

  // Division by a constant through a reciprocal: the estimate is at most one low.
  localparam int DIV_K   = RAW_W;
  localparam int RECIP_W = RAW_W;
  localparam int PROD_W  = RAW_W + RECIP_W;
  localparam int DIV_W   = 6;
  localparam int REM_W   = DIV_W + 1;
  localparam int DIFF_W  = RAW_W + DIV_W;

  localparam logic [RECIP_W-1:0] RECIP_MIN  = RECIP_W'((1 << DIV_K) / MINUTES_PER_HOUR);
  localparam logic [RECIP_W-1:0] RECIP_HOUR = RECIP_W'((1 << DIV_K) / HOURS_PER_DAY);
  localparam logic [RECIP_W-1:0] RECIP_DAY  = RECIP_W'((1 << DIV_K) / DAYS_PER_WEEK);

  typedef enum logic [2:0] {
    NS_IDLE = 3'b001,
    NS_MUL  = 3'b010,
    NS_FIX  = 3'b100
  } nstate_t;

  typedef enum logic [1:0] {
    STG_MIN  = 2'd0,
    STG_HOUR = 2'd1,
    STG_DAY  = 2'd2
  } stage_t;

  nstate_t            state_r, state_nxt;
  stage_t             stage_r;
  logic               done_r;
  logic [RAW_W-1:0]   x_r;
  logic [RAW_W-1:0]   hour_r;
  logic [RAW_W-1:0]   day_r;
  logic [PROD_W-1:0]  prod_r;
  clk_time_t          result_r;

  logic [DIV_W-1:0]   div_c;
  logic [RECIP_W-1:0] recip_c;
  logic [RAW_W-1:0]   q_est;
  logic [DIFF_W-1:0]  rem_full;
  logic [REM_W-1:0]   rem_est;
  logic [REM_W-1:0]   rem_fix;
  logic [RAW_W-1:0]   q_fix;
  logic [RAW_W:0]     carry_sum;

  always_comb begin
    case (stage_r)
      STG_MIN: begin
        div_c   = DIV_W'(MINUTES_PER_HOUR);
        recip_c = RECIP_MIN;
      end
      STG_HOUR: begin
        div_c   = DIV_W'(HOURS_PER_DAY);
        recip_c = RECIP_HOUR;
      end
      default: begin
        div_c   = DIV_W'(DAYS_PER_WEEK);
        recip_c = RECIP_DAY;
      end
    endcase

    q_est    = prod_r[DIV_K +: RAW_W];
    rem_full = DIFF_W'(x_r) - DIFF_W'(q_est) * DIFF_W'(div_c);
    rem_est  = rem_full[REM_W-1:0];
    if (rem_est >= REM_W'(div_c)) begin
      rem_fix = rem_est - REM_W'(div_c);
      q_fix   = q_est + RAW_W'(1);
    end else begin
      rem_fix = rem_est;
      q_fix   = q_est;
    end

    if (stage_r == STG_MIN) begin
      carry_sum = (RAW_W + 1)'(hour_r) + (RAW_W + 1)'(q_fix);
    end else begin
      carry_sum = (RAW_W + 1)'(day_r) + (RAW_W + 1)'(q_fix);
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      NS_IDLE: if (start) state_nxt = NS_MUL;
      NS_MUL:  state_nxt = NS_FIX;
      NS_FIX:  state_nxt = (stage_r == STG_DAY) ? NS_IDLE : NS_MUL;
      default: state_nxt = NS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= NS_IDLE;
      stage_r <= STG_MIN;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_r == NS_FIX) && (stage_r == STG_DAY);
      if (state_r == NS_IDLE && start) begin
        stage_r <= STG_MIN;
      end else if (state_r == NS_FIX) begin
        case (stage_r)
          STG_MIN:  stage_r <= STG_HOUR;
          STG_HOUR: stage_r <= STG_DAY;
          default:  stage_r <= STG_MIN;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      NS_IDLE: begin
        if (start) begin
          x_r    <= raw.minute;
          hour_r <= raw.hour;
          day_r  <= raw.day;
        end
      end
      NS_MUL: begin
        prod_r <= PROD_W'(x_r) * PROD_W'(recip_c);
      end
      NS_FIX: begin
        x_r <= carry_sum[RAW_W-1:0];
        case (stage_r)
          STG_MIN:  result_r.minute <= rem_fix[5:0];
          STG_HOUR: result_r.hour   <= rem_fix[4:0];
          default:  result_r.day    <= rem_fix[2:0];
        endcase
      end
      default: ;
    endcase
  end

  assign done   = done_r;
  assign result = result_r;

endmodule
`default_nettype wire

// ----- rtl/wcim_scan.sv -----
`default_nettype none
module wcim_scan import wcim_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic [WMIN_W-1:0]       now,
  input  wire logic [WINDOW_COUNT-1:0] valid,
  input  wire logic [WIN_W-1:0]        rd_data,
  output logic      [SLOT_IDX_W-1:0]   rd_addr,
  output scan_status_t                 status
);

  typedef enum logic [1:0] {
    SS_IDLE = 2'b01,
    SS_RUN  = 2'b10
  } sstate_t;

  sstate_t               state_r, state_nxt;
  logic [SLOT_IDX_W-1:0] chk_r;
  logic [WMIN_W-1:0]     now_r;
  logic                  done_r;
  logic [SLOT_CNT_W-1:0] slot_r;

  logic [WMIN_W-1:0]     win_lo;
  logic [WMIN_W-1:0]     win_hi;
  logic                  hit;
  logic                  last;

  // The read data in a run cycle belongs to the entry held in chk_r.
  assign win_lo = rd_data[WIN_W-1:WMIN_W];
  assign win_hi = rd_data[WMIN_W-1:0];
  assign hit    = valid[chk_r] && (now_r > win_lo) && (now_r < win_hi);
  assign last   = (chk_r == SLOT_IDX_W'(WINDOW_COUNT - 1));

  always_comb begin
    if (state_r == SS_RUN && !hit && !last) begin
      rd_addr = chk_r + SLOT_IDX_W'(1);
    end else begin
      rd_addr = '0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      SS_IDLE: if (start) state_nxt = SS_RUN;
      SS_RUN:  if (hit || last) state_nxt = SS_IDLE;
      default: state_nxt = SS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SS_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_r == SS_RUN) && (hit || last);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == SS_IDLE) begin
      if (start) begin
        now_r <= now;
        chk_r <= '0;
      end
    end else begin
      if (hit) begin
        slot_r <= SLOT_CNT_W'(chk_r);
      end else if (last) begin
        slot_r <= SLOT_CNT_W'(WINDOW_COUNT);
      end else begin
        chk_r <= chk_r + SLOT_IDX_W'(1);
      end
    end
  end

  assign status.done = done_r;
  assign status.slot = slot_r;

endmodule
`default_nettype wire
